FILE: hw/rtl/lru_cache_hit_miss_cost_defines.svh
// assertion macros for the lru key cache
// used by lcc_datapath, no other dependencies
`ifndef LRU_CACHE_HIT_MISS_COST_DEFINES_SVH
`define LRU_CACHE_HIT_MISS_COST_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcc assertion failed");
// next-cycle implication
`define LCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcc assertion failed");
`else
`define LCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/lcc_pkg.sv
// shared types, constants and key folding for the lru key cache
// no dependencies
`timescale 1ns / 1ps

package lcc_pkg;

  localparam int LCC_MAX_WAYS  = 32;
  localparam int LCC_KEY_BYTES = 8;

  localparam int CFG_W   = 6;
  localparam int KEY_IN_W = 64;
  localparam int AGE_W   = 16;
  localparam int COST_W  = 3;
  localparam int SLOT_W  = 5;
  localparam int SUM_W   = 32;

  localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;
  localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
  localparam logic [COST_W-1:0] MISS_COST = 3'd5;
  localparam logic [AGE_W-1:0]  AGE_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } lcc_state_t;

  // commands from the controller
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } lcc_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic zero_ways;
    logic last_issue;
    logic out_free;
  } lcc_sts_t;

  // fold ascii upper case letters to lower case, byte by byte
  function automatic logic [KEY_IN_W-1:0] fold_key(input logic [KEY_IN_W-1:0] k);
    logic [KEY_IN_W-1:0] r;
    logic [7:0] c;
    r = '0;
    for (int b = 0; b < KEY_IN_W / 8; b++) begin
      c = k[8*b +: 8];
      if (c inside {[8'h41:8'h5A]}) begin
        c = c + 8'h20;
      end
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/lru_cache_hit_miss_cost.sv
// Fully associative key cache with per-way ages and lru replacement.
// Flow: accept in idle, scan the n ways (n = ways in use capped at MAX_WAYS), drain, then
// commit once the output register is free; with n = 0 the scan and drain are skipped.
// One item at a time; the scan reads one way per cycle, one read port per key/age memory.
// Reset (synchronous, rst_n low) clears valid bits, ages in effect and the total at once.
`timescale 1ns / 1ps

module lru_cache_hit_miss_cost import lcc_pkg::*; #(
  parameter int MAX_WAYS  = LCC_MAX_WAYS,
  parameter int KEY_BYTES = LCC_KEY_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_IN_W-1:0] in_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [COST_W-1:0]   out_cost,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [SUM_W-1:0]    out_total_cost,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_ways_in_use
);

  lcc_cmd_t cmd;
  lcc_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  lcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // datapath
  lcc_datapath #(
    .MAX_WAYS  (MAX_WAYS),
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_key          (in_key),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_ways_in_use (cfg_ways_in_use),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_cost        (out_cost),
    .out_slot        (out_slot),
    .out_total_cost  (out_total_cost)
  );

endmodule

FILE: hw/rtl/lcc_ctrl.sv
// controller state machine for the lru key cache
// depends on lcc_pkg
`timescale 1ns / 1ps

module lcc_ctrl import lcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output lcc_cmd_t cmd_o,
  input  lcc_sts_t sts_i
);

  lcc_state_t state_r;
  lcc_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.start = 1'b1;
          state_nxt   = sts_i.zero_ways ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lcc_datapath.sv
// datapath of the lru key cache: key and age memories, valid bits,
// scan trackers, cost total and output register; depends on lcc_pkg
`timescale 1ns / 1ps
`include "lru_cache_hit_miss_cost_defines.svh"

module lcc_datapath import lcc_pkg::*; #(
  parameter int MAX_WAYS  = LCC_MAX_WAYS,
  parameter int KEY_BYTES = LCC_KEY_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcc_cmd_t            cmd_i,
  output lcc_sts_t            sts_o,
  input  logic [KEY_IN_W-1:0] in_key,
  input  logic                cfg_valid,
  input  logic [CFG_W-1:0]    cfg_ways_in_use,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [COST_W-1:0]   out_cost,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [SUM_W-1:0]    out_total_cost
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KEY_W = 8 * KEY_BYTES;

  // memories
  logic [KEY_W-1:0] key_mem [MAX_WAYS];
  logic [AGE_W-1:0] age_mem [MAX_WAYS];
  logic [KEY_W-1:0] rd_key_r;
  logic [AGE_W-1:0] rd_age_r;

  // registers
  logic [CFG_W-1:0]    cfg_r;
  logic [CNT_W-1:0]    n_r,          n_nxt;
  logic                zero_r,       zero_nxt;
  logic [KEY_W-1:0]    key_r,        key_nxt;
  logic [WAY_W-1:0]    idx_r,        idx_nxt;
  logic [WAY_W-1:0]    idx_d_r,      idx_d_nxt;
  logic                pend_r,       pend_nxt;
  logic [MAX_WAYS-1:0] valid_r,      valid_nxt;
  logic                hit_r,        hit_nxt;
  logic [WAY_W-1:0]    hit_slot_r,   hit_slot_nxt;
  logic                empty_r,      empty_nxt;
  logic [WAY_W-1:0]    empty_slot_r, empty_slot_nxt;
  logic [AGE_W-1:0]    best_age_r,   best_age_nxt;
  logic [WAY_W-1:0]    best_slot_r,  best_slot_nxt;
  logic [SUM_W-1:0]    sum_r,        sum_nxt;
  logic                out_valid_r,  out_valid_nxt;
  logic                out_hit_r,    out_hit_nxt;
  logic [COST_W-1:0]   out_cost_r,   out_cost_nxt;
  logic [SLOT_W-1:0]   out_slot_r,   out_slot_nxt;

  // combinational helpers
  logic [CMP_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  n_eff;
  logic              v_sel;
  logic [AGE_W-1:0]  aged;
  logic              match;
  logic [WAY_W-1:0]  slot_sel;
  logic [COST_W-1:0] cost;
  logic [SUM_W:0]    sum_plus;
  logic              fill;
  logic              age_we;
  logic [WAY_W-1:0]  age_waddr;
  logic [AGE_W-1:0]  age_wdata;

  // ways in use, limited to the physical way count
  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    n_eff   = (cfg_ext > CMP_W'(MAX_WAYS)) ? CNT_W'(MAX_WAYS) : CNT_W'(cfg_ext);
  end

  // scan stage: aging and key match; first empty and oldest way are tracked below
  always_comb begin
    v_sel = valid_r[idx_d_r];
    aged  = (v_sel && (rd_age_r != AGE_MAX)) ? rd_age_r + AGE_W'(1) : rd_age_r;
    match = pend_r && v_sel && (rd_key_r == key_r);
  end

  // slot, cost and saturating total for the commit
  always_comb begin
    if (hit_r) begin
      slot_sel = hit_slot_r;
    end else if (empty_r) begin
      slot_sel = empty_slot_r;
    end else begin
      slot_sel = best_slot_r;
    end
    cost     = hit_r ? HIT_COST : MISS_COST;
    sum_plus = {1'b0, sum_r} + (SUM_W + 1)'(cost);
    fill     = cmd_i.commit && !zero_r && !hit_r;
  end

  // age memory write port: aging during the scan, clear at commit
  always_comb begin
    age_we    = 1'b0;
    age_waddr = idx_d_r;
    age_wdata = aged;
    if (pend_r && v_sel) begin
      age_we = 1'b1;
    end else if (cmd_i.commit && !zero_r) begin
      age_we    = 1'b1;
      age_waddr = slot_sel;
      age_wdata = '0;
    end
  end

  // next values
  always_comb begin
    n_nxt          = n_r;
    zero_nxt       = zero_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    idx_d_nxt      = idx_r;
    pend_nxt       = cmd_i.step;
    valid_nxt      = valid_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    empty_nxt      = empty_r;
    empty_slot_nxt = empty_slot_r;
    best_age_nxt   = best_age_r;
    best_slot_nxt  = best_slot_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_cost_nxt   = out_cost_r;
    out_slot_nxt   = out_slot_r;

    // take a new item
    if (cmd_i.start) begin
      n_nxt         = n_eff;
      zero_nxt      = (n_eff == '0);
      key_nxt       = KEY_W'(fold_key(in_key));
      idx_nxt       = '0;
      hit_nxt       = 1'b0;
      hit_slot_nxt  = '0;
      empty_nxt     = 1'b0;
      empty_slot_nxt = '0;
      best_age_nxt  = '0;
      best_slot_nxt = '0;
    end

    // issue the next read
    if (cmd_i.step) begin
      idx_nxt = idx_r + WAY_W'(1);
    end

    // process the way read last cycle
    if (pend_r) begin
      if (match && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = idx_d_r;
      end
      if (!v_sel && !empty_r) begin
        empty_nxt      = 1'b1;
        empty_slot_nxt = idx_d_r;
      end
      if (aged > best_age_r) begin
        best_age_nxt  = aged;
        best_slot_nxt = idx_d_r;
      end
    end

    // update the cache and load the output register
    if (cmd_i.commit) begin
      if (fill) begin
        valid_nxt[slot_sel] = 1'b1;
      end
      sum_nxt       = sum_plus[SUM_W] ? '1 : sum_plus[SUM_W-1:0];
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit_r && !zero_r;
      out_cost_nxt  = cost;
      out_slot_nxt  = zero_r ? '0 : SLOT_W'(slot_sel);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_ways_in_use;
      end
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    zero_r       <= zero_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    idx_d_r      <= idx_d_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    empty_r      <= empty_nxt;
    empty_slot_r <= empty_slot_nxt;
    best_age_r   <= best_age_nxt;
    best_slot_r  <= best_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_cost_r   <= out_cost_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // key memory
  always_ff @(posedge clk) begin
    if (fill) begin
      key_mem[slot_sel] <= key_r;
    end
    rd_key_r <= key_mem[idx_r];
  end

  // age memory
  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    rd_age_r <= age_mem[idx_r];
  end

  // status and outputs
  always_comb begin
    sts_o.zero_ways  = (n_eff == '0);
    sts_o.last_issue = (CNT_W'(idx_r) + CNT_W'(1) == n_r);
    sts_o.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_cost       = out_cost_r;
  assign out_slot       = out_slot_r;
  assign out_total_cost = sum_r;

  // checks
  `LCC_ASSERT_IMP(a_step_in_range, clk, rst_n, cmd_i.step, CNT_W'(idx_r) < n_r)
  `LCC_ASSERT_IMP(a_commit_drained, clk, rst_n, cmd_i.commit, !pend_r && !cmd_i.step)
  `LCC_ASSERT_IMP(a_hit_is_valid, clk, rst_n, cmd_i.commit && hit_r, valid_r[hit_slot_r])
  `LCC_ASSERT_NXT(a_sum_monotone, clk, rst_n, cmd_i.commit, sum_r >= $past(sum_r))

endmodule

FILE: verif/lru_cache_hit_miss_cost_tb.sv
// self-checking testbench for the lru key cache: hit/miss, slot, cost and running total
// depends on lcc_pkg and lru_cache_hit_miss_cost
`timescale 1ns / 1ps

module lru_cache_hit_miss_cost_tb;
  import lcc_pkg::*;

  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         LONG_HOLD_CYC = 400;
  localparam int         DRAIN_CYC     = 40;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT      = 8'h20;

  typedef struct packed {
    logic              hit;
    logic [COST_W-1:0] cost;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0]  total;
  } access_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KEY_IN_W-1:0] in_key;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [COST_W-1:0]   out_cost;
  logic [SLOT_W-1:0]   out_slot;
  logic [SUM_W-1:0]    out_total_cost;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_ways_in_use;

  // shadow copy of the cache contents
  logic [KEY_IN_W-1:0] shadow_key   [LCC_MAX_WAYS];
  logic                shadow_valid [LCC_MAX_WAYS];
  logic [AGE_W-1:0]    shadow_age   [LCC_MAX_WAYS];
  logic [SUM_W-1:0]    shadow_total;
  logic [CFG_W-1:0]    shadow_ways;

  access_result_t pending_results[$];

  int  error_count;
  int  cycle_count;
  int  items_sent;
  int  hit_count;
  int  miss_count;
  int  settings_seen;
  bit  idle_on;
  bit  long_hold;

  lru_cache_hit_miss_cost DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_cost       (out_cost),
    .out_slot       (out_slot),
    .out_total_cost (out_total_cost),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_ways_in_use(cfg_ways_in_use)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // lower-case the ascii letters of the key, dropping bytes past the key length
  function automatic logic [KEY_IN_W-1:0] fold_case(input logic [KEY_IN_W-1:0] raw);
    logic [KEY_IN_W-1:0] folded;
    logic [7:0]          ch;
    folded = '0;
    for (int b = 0; b < KEY_IN_W / 8; b++) begin
      ch = raw[8*b +: 8];
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
        ch = ch | CASE_BIT;
      end
      if (b < LCC_KEY_BYTES) begin
        folded[8*b +: 8] = ch;
      end
    end
    return folded;
  endfunction

  // one cache access on the shadow state: age, match, else fill or evict
  function automatic access_result_t predict_access(input logic [KEY_IN_W-1:0] raw);
    access_result_t      res;
    logic [KEY_IN_W-1:0] k;
    int                  n;
    int                  slot;
    int                  best_age;
    bit                  hit;
    bit                  found;
    k     = fold_case(raw);
    n     = (shadow_ways > LCC_MAX_WAYS) ? LCC_MAX_WAYS : int'(shadow_ways);
    hit   = 1'b0;
    found = 1'b0;
    slot  = 0;
    if (n != 0) begin
      for (int i = 0; i < n; i++) begin
        if (shadow_valid[i]) begin
          if (shadow_age[i] != AGE_MAX) begin
            shadow_age[i] = shadow_age[i] + 1'b1;
          end
          if (!hit && shadow_key[i] == k) begin
            hit           = 1'b1;
            slot          = i;
            shadow_age[i] = '0;
          end
        end
      end
      if (!hit) begin
        for (int i = 0; i < n && !found; i++) begin
          if (!shadow_valid[i]) begin
            found = 1'b1;
            slot  = i;
          end
        end
        // no empty way: evict the oldest, lowest index on ties
        if (!found) begin
          slot     = 0;
          best_age = shadow_age[0];
          for (int i = 1; i < n; i++) begin
            if (shadow_age[i] > best_age) begin
              best_age = shadow_age[i];
              slot     = i;
            end
          end
        end
        shadow_key[slot]   = k;
        shadow_valid[slot] = 1'b1;
        shadow_age[slot]   = '0;
      end
    end
    res.hit  = hit;
    res.cost = hit ? HIT_COST : MISS_COST;
    res.slot = slot[SLOT_W-1:0];
    if (shadow_total > {SUM_W{1'b1}} - res.cost) begin
      shadow_total = {SUM_W{1'b1}};
    end else begin
      shadow_total = shadow_total + res.cost;
    end
    res.total = shadow_total;
    return res;
  endfunction

  // result checking first, then prediction for the item accepted at this edge
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no access outstanding: hit %0d slot %0d", out_hit, out_slot);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, out_hit);
            error_count++;
          end
          if (out_cost !== want.cost) begin
            $error("cost: expected %0d actual %0d", want.cost, out_cost);
            error_count++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d actual %0d", want.slot, out_slot);
            error_count++;
          end
          if (out_total_cost !== want.total) begin
            $error("total_cost: expected %0d actual %0d", want.total, out_total_cost);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        shadow_ways = cfg_ways_in_use;
      end
      if (in_valid && !in_stall) begin
        want = predict_access(in_key);
        pending_results.push_back(want);
        items_sent++;
        if (want.hit) hit_count++;
        else miss_count++;
      end
    end
  end

  // receiver: random stall bursts, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYC) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // offer one key, leaving valid high after acceptance
  task automatic send_key(input logic [KEY_IN_W-1:0] k);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_key   = k;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] ways);
    wait_drained();
    cfg_valid       = 1'b1;
    cfg_ways_in_use = ways;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_seen++;
  endtask

  function automatic logic [KEY_IN_W-1:0] random_wide_key();
    return {$urandom(), $urandom()};
  endfunction

  // short text key of letters mixed with the bytes either side of each letter range
  function automatic logic [KEY_IN_W-1:0] random_text_key();
    logic [KEY_IN_W-1:0] k;
    int                  len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int b = 0; b < len; b++) begin
      case ($urandom_range(0, 4))
        0:       k[8*b +: 8] = CHAR_UPPER_A + 8'($urandom_range(0, 25));
        1, 2:    k[8*b +: 8] = CHAR_LOWER_A + 8'($urandom_range(0, 25));
        3:       k[8*b +: 8] = CHAR_UPPER_A - 8'd1 + 8'($urandom_range(0, 1) * 27);
        default: k[8*b +: 8] = CHAR_LOWER_A - 8'd1 + 8'($urandom_range(0, 1) * 27);
      endcase
    end
    return k;
  endfunction

  // flip the case of some letters so that the key still folds to the same value
  function automatic logic [KEY_IN_W-1:0] scramble_case(input logic [KEY_IN_W-1:0] k);
    logic [KEY_IN_W-1:0] r;
    logic [7:0]          lc;
    r = k;
    for (int b = 0; b < KEY_IN_W / 8; b++) begin
      lc = k[8*b +: 8] | CASE_BIT;
      if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z && $urandom_range(0, 1)) begin
        r[8*b +: 8] = k[8*b +: 8] ^ CASE_BIT;
      end
    end
    return r;
  endfunction

  // default of 32 ways after reset: zero key, all ones, case folding, letter boundaries
  task automatic test_reset_default();
    send_key('0);
    send_key({KEY_IN_W{1'b1}});
    send_key(64'h0000_0000_4B45_5931);
    send_key(64'h0000_0000_6B65_7931);
    send_key('0);
    send_key(64'h4041_5A5B_6061_7A7B);
    send_key(64'h4061_7A5B_6041_5A7B);
    wait_drained();
  endtask

  // zero ways: every access misses in slot 0 and only the total moves
  task automatic test_caching_disabled();
    write_ways(6'd0);
    send_key('0);
    send_key(64'h0000_0000_6B65_7931);
    send_key(64'h0000_0000_6B65_7931);
    wait_drained();
  endtask

  // way counts above the maximum act as the maximum
  task automatic test_oversized_ways();
    write_ways(6'd63);
    send_key(64'h0000_0000_4B45_5931);
    send_key({KEY_IN_W{1'b1}});
    write_ways(6'd33);
    send_key(64'h1234_5678_9ABC_DEF0);
    wait_drained();
  endtask

  // three ways: fill, then force eviction of the oldest
  task automatic test_eviction();
    write_ways(6'd3);
    send_key(64'h0000_0000_0000_0041);
    send_key(64'h0000_0000_0000_0042);
    send_key(64'h0000_0000_0000_0043);
    send_key(64'h0000_0000_0000_0061);
    send_key(64'h0000_0000_0000_0044);
    wait_drained();
  endtask

  // ways taken out of use keep their keys and ages until brought back
  task automatic test_ways_out_of_use();
    write_ways(6'd1);
    send_key(64'h0000_0000_0000_0043);
    send_key(64'h0000_0000_0000_0045);
    write_ways(6'd3);
    send_key(64'h0000_0000_0000_0063);
    send_key(64'h0000_0000_0000_0042);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_output_backpressure();
    write_ways(6'd32);
    idle_on   = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_key(random_text_key());
    end
    wait_drained();
  endtask

  // random accesses over a key set a little larger than the ways in use
  task automatic test_random_phase(input logic [CFG_W-1:0] ways, input int count,
                                   input bit with_idle);
    logic [KEY_IN_W-1:0] pool [40];
    int                  pool_size;
    int                  eff;
    int                  pick;
    write_ways(ways);
    idle_on   = with_idle;
    eff       = (ways > LCC_MAX_WAYS) ? LCC_MAX_WAYS : int'(ways);
    pool_size = eff + $urandom_range(1, 8);
    if (pool_size > 40) pool_size = 40;
    for (int i = 0; i < pool_size; i++) begin
      pool[i] = $urandom_range(0, 1) ? random_text_key() : random_wide_key();
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_key(scramble_case(pool[$urandom_range(0, pool_size - 1)]));
      end else if (pick < 9) begin
        send_key(random_wide_key());
      end else begin
        send_key($urandom_range(0, 1) ? '0 : {KEY_IN_W{1'b1}});
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_key          = '0;
    cfg_valid       = 1'b0;
    cfg_ways_in_use = '0;
    idle_on         = 1'b1;
    long_hold       = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    items_sent      = 0;
    hit_count       = 0;
    miss_count      = 0;
    settings_seen   = 1;
    shadow_total    = '0;
    shadow_ways     = CFG_RESET;
    for (int i = 0; i < LCC_MAX_WAYS; i++) begin
      shadow_key[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i]   = '0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_reset_default();
    test_caching_disabled();
    test_oversized_ways();
    test_eviction();
    test_ways_out_of_use();
    test_output_backpressure();
    test_random_phase(6'd1, 100, 1'b1);
    test_random_phase(6'd2, 100, 1'b1);
    test_random_phase(6'd5, 100, 1'b1);
    test_random_phase(6'd8, 100, 1'b1);
    test_random_phase(6'd31, 100, 1'b1);
    test_random_phase(6'd32, 100, 1'b1);
    test_random_phase(6'd0, 100, 1'b1);
    test_random_phase(6'd63, 100, 1'b1);
    test_random_phase(6'd16, 100, 1'b1);
    test_random_phase(6'd3, 100, 1'b1);
    test_random_phase(6'd12, 100, 1'b0);

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    $display("run covered %0d accesses (%0d hits, %0d misses) over %0d way settings",
             items_sent, hit_count, miss_count, settings_seen);
    $display("including disabled, oversized and out-of-use ways and a long output hold");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
